@@ hw/rtl/bsum_pkg.sv @@
package bsum_pkg;

    // fixed field widths of the stream and the register port
    localparam int PIX_W   = 16;
    localparam int RES_W   = 21;
    localparam int FW_W    = 11;
    localparam int FH_W    = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

@@ hw/rtl/bsum_linebuf.sv @@
module bsum_linebuf import bsum_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_WIDTH,
    parameter int DATA_W = 4 * DEF_SAMPLE_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    output logic [DATA_W-1:0] rd_data,
    output logic              clearing
);

    localparam int ADDR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_q_reg;
    logic              byp_reg;
    logic [DATA_W-1:0] byp_data_reg;
    logic              clr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg     <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            byp_reg      <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            // same column read while it is being written: take the new data
            if (rd_en) begin
                byp_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    assign rd_data  = byp_reg ? byp_data_reg : rd_q_reg;
    assign clearing = clr_reg;

`ifndef NO_ASSERTIONS
    a_no_access_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !rd_en && !wr_en)
        else $error("line buffer accessed during clearing pass");
    a_clear_length: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_reg) |-> $past(clr_addr_reg) == ADDR_W'(DEPTH - 1))
        else $error("clearing pass ended early");
    a_bypass_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && wr_en && (wr_addr == rd_addr) |=> byp_reg && rd_data == $past(wr_data))
        else $error("read after write to same column missed bypass");
`endif

endmodule

@@ hw/rtl/box_sum_5x5_border_keep.sv @@
// 5x5 box sum over a raster stream, border pixels passed through.
// registered in the window stage, then the result register; in stream terms a
// pixel's result comes 2*width+2 beats after the pixel. throughput: one beat
// per cycle while m_ready holds back no result and no clearing pass runs, set by one
// read and one write per cycle on the line buffer. reset: synchronous, active low; then a
// clearing pass zeroes all MAX_WIDTH line buffer entries while s_ready is held low.
module box_sum_5x5_border_keep import bsum_pkg::*; #(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PIX_W-1:0] s_pixel,
    input  logic                    s_is_flush,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RES_W-1:0] m_result_value,
    output logic                    m_is_border,
    output logic                    m_end_of_frame
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W = $clog2(2 * MAX_WIDTH + 3);
    localparam int CSUM_W = SAMPLE_BITS + 3;
    localparam int TOT_W  = SAMPLE_BITS + 5;
    localparam int LB_W   = 4 * SAMPLE_BITS;

    // configuration
    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= FW_W'(RESET_WIDTH);
            fh_reg <= FH_W'(RESET_HEIGHT);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  fw_reg <= FW_W'(cfg_data);
                REG_FRAME_HEIGHT: fh_reg <= FH_W'(cfg_data);
                default: ;
            endcase
        end
    end

    logic [WID_W-1:0]  eff_w;
    logic [FH_W-1:0]   eff_h;
    logic [PEND_W-1:0] depth;

    always_comb begin
        if (fw_reg == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(fw_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(fw_reg);
        end
        eff_h = (fh_reg == '0) ? FH_W'(1) : fh_reg;
        depth = PEND_W'({eff_w, 1'b0}) + PEND_W'(2);
    end

    // input and output positions and pending count
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [FH_W-1:0]   in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [FH_W-1:0]   out_row_reg, out_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [WID_W:0] in_col_inc, out_col_inc, out_col_p2;
    logic [FH_W:0]  in_row_inc, out_row_inc, out_row_p2;

    logic acc, push, emit, interior, eof, pend_zero, pend_full;
    logic signed [SAMPLE_BITS-1:0] sample;

    logic s1_valid_reg, s1_emit_reg, s1_interior_reg, s1_eof_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic s1_adv;

    logic m_valid_reg;
    logic signed [RES_W-1:0] m_value_reg;
    logic m_border_reg, m_eof_reg;

    logic lb_clearing;
    logic [LB_W-1:0] lb_rd_data, lb_wr_data;

    assign s1_adv  = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_ready);
    assign s_ready = !lb_clearing && (!s1_valid_reg || s1_adv);

    always_comb begin
        acc       = s_valid && s_ready;
        pend_zero = (pend_reg == '0);
        pend_full = (pend_reg >= depth);
        push      = acc && (!s_is_flush || !pend_zero);
        emit      = acc && (s_is_flush ? !pend_zero : pend_full);
        sample    = s_is_flush ? '0 : SAMPLE_BITS'(s_pixel);

        in_col_inc  = (WID_W+1)'(in_col_reg) + 1'b1;
        in_row_inc  = (FH_W+1)'(in_row_reg) + 1'b1;
        out_col_inc = (WID_W+1)'(out_col_reg) + 1'b1;
        out_row_inc = (FH_W+1)'(out_row_reg) + 1'b1;
        out_col_p2  = (WID_W+1)'(out_col_reg) + (WID_W+1)'(2);
        out_row_p2  = (FH_W+1)'(out_row_reg) + (FH_W+1)'(2);

        interior = (out_row_reg >= FH_W'(2)) && (out_row_p2 < (FH_W+1)'(eff_h)) &&
                   (out_col_reg >= COL_W'(2)) && (out_col_p2 < (WID_W+1)'(eff_w));
        eof      = (out_col_inc >= (WID_W+1)'(eff_w)) && (out_row_inc >= (FH_W+1)'(eff_h));

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (push) begin
            if (in_col_inc >= (WID_W+1)'(eff_w)) begin
                in_col_next = '0;
                in_row_next = (in_row_inc >= (FH_W+1)'(eff_h)) ? '0 : FH_W'(in_row_inc);
            end else begin
                in_col_next = COL_W'(in_col_inc);
            end
        end

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (emit) begin
            if (out_col_inc >= (WID_W+1)'(eff_w)) begin
                out_col_next = '0;
                out_row_next = (out_row_inc >= (FH_W+1)'(eff_h)) ? '0 : FH_W'(out_row_inc);
            end else begin
                out_col_next = COL_W'(out_col_inc);
            end
        end

        pend_next = pend_reg;
        if (acc) begin
            if (s_is_flush) begin
                if (!pend_zero) pend_next = pend_reg - 1'b1;
            end else if (pend_full) begin
                pend_next = depth;
            end else begin
                pend_next = pend_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            if (s_ready) begin
                s1_valid_reg <= push;
                s1_emit_reg  <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            s1_sample_reg   <= sample;
            s1_addr_reg     <= in_col_reg;
            s1_interior_reg <= interior;
            s1_eof_reg      <= eof;
        end
    end

    bsum_linebuf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LB_W)
    ) u_linebuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (push),
        .rd_addr  (in_col_reg),
        .wr_en    (s1_adv),
        .wr_addr  (s1_addr_reg),
        .wr_data  (lb_wr_data),
        .rd_data  (lb_rd_data),
        .clearing (lb_clearing)
    );

    // window: column sums, running total and the center row taps
    logic signed [SAMPLE_BITS-1:0] lane [4];
    logic signed [SAMPLE_BITS-1:0] mid_reg [2];
    logic signed [CSUM_W-1:0] col_sum_reg [5];
    logic signed [CSUM_W-1:0] new_csum;
    logic signed [TOT_W-1:0]  total_reg, total_next;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            lane[r] = $signed(lb_rd_data[r*SAMPLE_BITS +: SAMPLE_BITS]);
        end
        // each column shifts up one row, newest sample at the bottom
        lb_wr_data = {s1_sample_reg, lane[3], lane[2], lane[1]};
        new_csum   = CSUM_W'(lane[0]) + CSUM_W'(lane[1]) + CSUM_W'(lane[2]) +
                     CSUM_W'(lane[3]) + CSUM_W'(s1_sample_reg);
        total_next = total_reg - TOT_W'(col_sum_reg[0]) + TOT_W'(new_csum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            for (int k = 0; k < 5; k++) col_sum_reg[k] <= '0;
            for (int k = 0; k < 2; k++) mid_reg[k] <= '0;
        end else if (s1_adv) begin
            total_reg <= total_next;
            for (int k = 0; k < 4; k++) col_sum_reg[k] <= col_sum_reg[k+1];
            col_sum_reg[4] <= new_csum;
            mid_reg[0] <= mid_reg[1];
            mid_reg[1] <= lane[2];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            // mid_reg[0] becomes the window center on this beat
            m_value_reg  <= s1_interior_reg ? RES_W'(total_next) : RES_W'(mid_reg[0]);
            m_border_reg <= !s1_interior_reg;
            m_eof_reg    <= s1_eof_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_is_border    = m_border_reg;
    assign m_end_of_frame = m_eof_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        lb_clearing |-> !s_ready)
        else $error("beat accepted during line buffer clear");
    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |-> m_valid_reg && !m_ready && s1_emit_reg)
        else $error("window stage stalled without a blocked result");
    a_idle_flush_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_is_flush && pend_reg == '0 |=> !s1_valid_reg && pend_reg == '0)
        else $error("flush with nothing pending entered the pipeline");
`endif

endmodule

@@ bench/tb_box_sum_5x5_border_keep.sv @@
module tb_box_sum_5x5_border_keep;
    import bsum_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN      = DEF_MAX_WIDTH;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {STY_RANDOM, STY_EXTREME, STY_ALL_MAX, STY_ALL_MIN, STY_SMALL} pix_style_t;

    typedef struct {
        logic signed [PIX_W-1:0] pixel;
        logic                    flush;
    } pix_beat_t;

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic                    border;
        logic                    eof;
    } box_out_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    cfg_reg_t                cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [PIX_W-1:0] s_pixel = '0;
    logic                    s_is_flush = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [RES_W-1:0] m_result_value;
    logic                    m_is_border;
    logic                    m_end_of_frame;

    // stimulus control; the idle and hold settings are written by the sequencer at the falling edge
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_long = 1'b0;
    int hold_count = 0;
    int quiet_cycles = 0;

    pix_beat_t pixels_to_send[$];
    box_out_t  box_sums_due[$];

    int errors = 0;
    int beats_in = 0;
    int flushes_in = 0;
    int sums_checked = 0;
    int settings_run = 0;

    // filter state as the block should hold it
    logic [FW_W-1:0]         cfg_width;
    logic [FH_W-1:0]         cfg_height;
    logic signed [PIX_W-1:0] line_mem[4][LINE_LEN];
    logic signed [PIX_W-1:0] win[5][5];
    int unsigned             wr_col, wr_row, rd_col, rd_row, backlog;

    box_sum_5x5_border_keep i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel        (s_pixel),
        .s_is_flush     (s_is_flush),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_is_border    (m_is_border),
        .m_end_of_frame (m_end_of_frame)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_LEN) return LINE_LEN;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        return cfg_height;
    endfunction

    task automatic advance_pos(inout int unsigned col, inout int unsigned row,
                               input int unsigned w, input int unsigned h);
        if (col + 1 >= w) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endtask

    task automatic shift_window(input logic signed [PIX_W-1:0] pix,
                                input int unsigned w, input int unsigned h);
        int unsigned c;
        int r, k;
        c = (wr_col >= LINE_LEN) ? LINE_LEN - 1 : wr_col;
        for (r = 0; r < 5; r++)
            for (k = 0; k < 4; k++)
                win[r][k] = win[r][k+1];
        for (r = 0; r < 4; r++) win[r][4] = line_mem[r][c];
        win[4][4] = pix;
        for (r = 0; r < 3; r++) line_mem[r][c] = line_mem[r+1][c];
        line_mem[3][c] = pix;
        advance_pos(wr_col, wr_row, w, h);
    endtask

    task automatic emit_sum(input int unsigned w, input int unsigned h);
        box_out_t res;
        int acc;
        int r, k;
        bit interior;
        interior = rd_row >= 2 && rd_row + 2 < h && rd_col >= 2 && rd_col + 2 < w;
        acc = 0;
        if (interior) begin
            for (r = 0; r < 5; r++)
                for (k = 0; k < 5; k++)
                    acc = acc + win[r][k];
        end else begin
            acc = win[2][2];
        end
        res.value  = acc[RES_W-1:0];
        res.border = !interior;
        res.eof    = (rd_col + 1 >= w) && (rd_row + 1 >= h);
        box_sums_due.push_back(res);
        advance_pos(rd_col, rd_row, w, h);
    endtask

    task automatic predict_box_sum(input logic signed [PIX_W-1:0] pix, input logic flush);
        int unsigned w, h, depth;
        w = eff_width();
        h = eff_height();
        depth = 2 * w + 2;
        if (flush) begin
            // a flush with nothing in flight does nothing at all
            if (backlog == 0) return;
            shift_window('0, w, h);
            emit_sum(w, h);
            backlog--;
        end else begin
            shift_window(pix, w, h);
            if (backlog >= depth) begin
                backlog = depth;
                emit_sum(w, h);
            end else begin
                backlog++;
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin : driver
        pix_beat_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pixels_to_send.pop_front();
                s_valid    <= 1'b1;
                s_pixel    <= nxt.pixel;
                s_is_flush <= nxt.flush;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own count for the long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_count <= 0;
        end else if (hold_long && hold_count < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!hold_long) hold_count <= 0;
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on input beats, then check output beats
    always @(posedge aclk) begin : monitor
        box_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beats_in++;
                if (s_is_flush) flushes_in++;
                predict_box_sum(s_pixel, s_is_flush);
            end
            if (m_valid && m_ready) begin
                sums_checked++;
                if (box_sums_due.size() == 0) begin
                    $display("%0t: unexpected result beat value %0d border %0b eof %0b",
                             $time, m_result_value, m_is_border, m_end_of_frame);
                    errors++;
                end else begin
                    want = box_sums_due.pop_front();
                    if (m_result_value !== want.value) begin
                        $display("%0t: result_value expected %0d got %0d",
                                 $time, want.value, m_result_value);
                        errors++;
                    end
                    if (m_is_border !== want.border) begin
                        $display("%0t: is_border expected %0b got %0b",
                                 $time, want.border, m_is_border);
                        errors++;
                    end
                    if (m_end_of_frame !== want.eof) begin
                        $display("%0t: end_of_frame expected %0b got %0b",
                                 $time, want.eof, m_end_of_frame);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val[FW_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = val[FH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_beat(input logic signed [PIX_W-1:0] p, input logic f);
        pix_beat_t b;
        b.pixel = p;
        b.flush = f;
        pixels_to_send.push_back(b);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 23 : 0;
        stall_pct     = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 23 : 0;
    endtask

    task automatic wait_idle();
        while (pixels_to_send.size() != 0 || s_valid || box_sums_due.size() != 0)
            @(negedge aclk);
        // flushes on an empty pipe give no result, so give the block time to settle
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [PIX_W-1:0] pick_pixel(input pix_style_t style);
        int v;
        case (style)
            STY_EXTREME: return $urandom_range(1) ? PIX_MAX : PIX_MIN;
            STY_ALL_MAX: return PIX_MAX;
            STY_ALL_MIN: return PIX_MIN;
            STY_SMALL: begin
                v = $urandom_range(16);
                return PIX_W'(v - 8);
            end
            default: return PIX_W'($urandom());
        endcase
    endfunction

    task automatic run_phase(input int unsigned w_reg, input int unsigned h_reg,
                             input int n_pix, input int flush_pct,
                             input idle_mode_t mode, input bit hold);
        int unsigned w, h, area, fill, seg, n_drain;
        int total, i, r;
        pix_style_t style;
        write_reg(REG_FRAME_WIDTH, w_reg[CFG_W-1:0]);
        write_reg(REG_FRAME_HEIGHT, h_reg[CFG_W-1:0]);
        w = eff_width();
        h = eff_height();
        area = w * h;
        fill = 0;
        // for frames of at most 400 pixels, complete the frame the stream is in, so later frames start at the top left
        if (area <= 400 && wr_col < w && wr_row < h)
            fill = ((h - 1 - wr_row) * w + (w - wr_col)) % area;
        seg = (area <= 400) ? area : 64;
        total = fill + n_pix;
        style = STY_RANDOM;
        @(negedge aclk);
        set_idle(mode);
        hold_long = hold;
        for (i = 0; i < total; i++) begin
            if (i % seg == 0) begin
                r = $urandom_range(7);
                style = (r < 4) ? STY_RANDOM : pix_style_t'(r - 3);
            end
            push_beat(pick_pixel(style), 1'b0);
            if ($urandom_range(99) < flush_pct) push_beat('0, 1'b1);
        end
        n_drain = backlog + total;
        if (n_drain > 2 * w + 2) n_drain = 2 * w + 2;
        for (i = 0; i < n_drain; i++) push_beat('0, 1'b1);
        wait_idle();
        hold_long = 1'b0;
        settings_run++;
    endtask

    initial begin : sequencer
        int r, c, i;
        cfg_width  = FW_W'(RESET_WIDTH);
        cfg_height = FH_W'(RESET_HEIGHT);
        for (r = 0; r < 4; r++)
            for (c = 0; c < LINE_LEN; c++)
                line_mem[r][c] = '0;
        for (r = 0; r < 5; r++)
            for (c = 0; c < 5; c++)
                win[r][c] = '0;
        wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0; backlog = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // smallest frame with an interior pixel, all at the negative extreme
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(5));
        @(negedge aclk);
        set_idle(IDLE_NONE);
        push_beat('0, 1'b1);
        for (i = 0; i < 25; i++) push_beat(PIX_MIN, 1'b0);
        push_beat(PIX_MAX, 1'b0);
        push_beat('0, 1'b1);
        push_beat('0, 1'b1);
        wait_idle();
        settings_run++;

        // some beats are still in flight here, so the next width applies mid-stream
        run_phase(6,    7,     42,  0, IDLE_NONE, 1'b0);
        run_phase(8,    5,     40,  3, IDLE_SEND, 1'b0);
        run_phase(5,    9,     45,  0, IDLE_RECV, 1'b0);
        run_phase(12,   6,     72,  2, IDLE_BOTH, 1'b0);
        run_phase(0,    1,     20,  5, IDLE_NONE, 1'b0);
        run_phase(3,    4,     24,  5, IDLE_SEND, 1'b0);
        run_phase(7,    0,     21,  0, IDLE_RECV, 1'b0);
        run_phase(16,   5,     80,  0, IDLE_NONE, 1'b1);
        run_phase(2047, 65535, 40,  0, IDLE_BOTH, 1'b0);
        run_phase(1024, 3,     40,  0, IDLE_SEND, 1'b0);
        run_phase(1,    1,     15,  5, IDLE_RECV, 1'b0);
        run_phase(9,    8,     144, 1, IDLE_NONE, 1'b0);
        run_phase(10,   10,    200, 2, IDLE_BOTH, 1'b0);
        run_phase(5,    5,     50,  10, IDLE_SEND, 1'b0);
        run_phase(640,  480,   20,  0, IDLE_BOTH, 1'b0);

        repeat (16) @(posedge aclk);
        $display("covered %0d frame settings: %0d beats in, %0d of them flushes",
                 settings_run, beats_in, flushes_in);
        $display("%0d result beats checked, %0d mismatches", sums_checked, errors);
        if (errors == 0 && box_sums_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
